// ===== hw/rtl/drc_pkg.sv =====
// ----------------------------------------------------------------------------
// drc_pkg
// Shared types, codes and compact-target helpers for the retarget checker.
// ----------------------------------------------------------------------------
package drc_pkg;

	localparam int unsigned TGT_W  = 256;
	localparam int unsigned PROD_W = TGT_W + 32;
	localparam int unsigned CNT_W  = $clog2(PROD_W);
	localparam int unsigned NLIMB  = TGT_W / 32;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam logic [31:0] RST_GOAL_SPAN         = 32'd1209600;
	localparam logic [31:0] RST_MIN_TIMESPAN      = 32'd302400;
	localparam logic [31:0] RST_MAX_TIMESPAN      = 32'd4838400;
	localparam logic [31:0] RST_RETARGET_INTERVAL = 32'd2016;
	localparam logic [31:0] RST_POWLIMIT_BITS     = 32'h1d00ffff;

	typedef enum logic [2:0] {
		REG_GOAL_SPAN         = 3'd0,
		REG_MIN_TIMESPAN      = 3'd1,
		REG_MAX_TIMESPAN      = 3'd2,
		REG_RETARGET_INTERVAL = 3'd3,
		REG_POWLIMIT_BITS     = 3'd4
	} drc_reg_t;

	typedef enum logic [1:0] {
		ST_MATCH    = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_INVALID  = 2'd2
	} drc_status_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MOD, B_CHK, B_DEC, B_MUL, B_DIV, B_CAP, B_ENC, B_RES
	} drc_bstate_t;

	typedef struct packed {
		logic [31:0] goal_span;
		logic [31:0] min_timespan;
		logic [31:0] max_timespan;
		logic [31:0] retarget_interval;
		logic [31:0] powlimit_bits;
	} drc_cfg_t;

	typedef struct packed {
		logic [31:0] block_height;
		logic [31:0] parent_bits;
		logic [31:0] header_bits;
		logic [31:0] span;
	} drc_item_t;

	typedef struct packed {
		logic             ok;
		logic [TGT_W-1:0] v;
	} drc_dec_t;

	function automatic drc_dec_t drc_decode(input logic [31:0] bits);
		logic [7:0]       e;
		logic [22:0]      m;
		logic             mnz;
		logic [TGT_W-1:0] wide;
		drc_dec_t         r;
		e    = bits[31:24];
		m    = bits[22:0];
		mnz  = (m != 23'd0);
		wide = {{(TGT_W-23){1'b0}}, m};
		r.ok = !(mnz && bits[23]) &&
		       !(mnz && ((e > 8'd34) || ((m > 23'hFF) && (e > 8'd33)) ||
		                 ((m > 23'hFFFF) && (e > 8'd32))));
		if (e <= 8'd3)
			r.v = wide >> {(8'd3 - e), 3'b000};
		else
			r.v = wide << {(e - 8'd3), 3'b000};
		return r;
	endfunction

	function automatic logic [31:0] drc_encode(input logic [TGT_W-1:0] v);
		logic [5:0]       size;
		logic [23:0]      c;
		logic [TGT_W-1:0] sh;
		size = 6'd0;
		for (int k = 0; k < TGT_W / 8; k++) begin
			if (v[8*k +: 8] != 8'd0)
				size = 6'(k + 1);
		end
		if (size <= 6'd3) begin
			sh = v << {(6'd3 - size), 3'b000};
			c  = sh[23:0];
		end else begin
			sh = v >> {(size - 6'd3), 3'b000};
			c  = sh[23:0];
		end
		if (c[23]) begin
			c    = {8'd0, c[23:8]};
			size = size + 6'd1;
		end
		return {2'b00, size, c};
	endfunction

endpackage

// ===== hw/rtl/drc_front.sv =====
// ----------------------------------------------------------------------------
// drc_front
// Input stage: takes an item, works out the clamped period span, hands on.
// ----------------------------------------------------------------------------
module drc_front import drc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  drc_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] block_height,
	input  logic [31:0] parent_bits,
	input  logic [31:0] period_start,
	input  logic [31:0] period_end,
	input  logic [31:0] header_bits,
	output logic        push,
	output drc_item_t   push_item,
	input  logic        q_full
);

	logic        v_s1;
	drc_item_t   item_s1;
	logic [31:0] raw;
	logic [31:0] span;
	logic        take;

	always_comb begin
		raw = (period_end < period_start) ? 32'd0 : period_end - period_start;
		if (raw == 32'd0)
			raw = cfg.goal_span;
		if (raw < cfg.min_timespan)
			span = cfg.min_timespan;
		else if (raw > cfg.max_timespan)
			span = cfg.max_timespan;
		else
			span = raw;
	end

	assign push      = v_s1 && !q_full;
	assign push_item = item_s1;
	assign in_stall  = v_s1 && q_full;
	assign take      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.block_height <= block_height;
			item_s1.parent_bits  <= parent_bits;
			item_s1.header_bits  <= header_bits;
			item_s1.span         <= span;
		end
	end

endmodule

// ===== hw/rtl/drc_queue.sv =====
// ----------------------------------------------------------------------------
// drc_queue
// Small FIFO between the front stage and the compute engine.
// ----------------------------------------------------------------------------
module drc_queue import drc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  drc_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      q_valid,
	output drc_item_t pop_item
);

	drc_item_t         mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign pop_item = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

endmodule

// ===== hw/rtl/drc_back.sv =====
// ----------------------------------------------------------------------------
// drc_back
// Compute engine: boundary test, 256x32 multiply, bit-serial divide, cap,
// re-encode and result register.
// ----------------------------------------------------------------------------
module drc_back import drc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  drc_cfg_t    cfg,
	input  logic        q_valid,
	input  drc_item_t   pop_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] want_bits,
	output logic [1:0]  check_status,
	output logic        was_retarget
);

	drc_bstate_t       state_q, state_d;
	drc_item_t         it_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] div_q;
	logic [31:0]       rem_q;
	logic [TGT_W-1:0]  old_q;
	logic [TGT_W-1:0]  lim_q;
	logic [31:0]       carry_q;
	logic [31:0]       exp_q;
	drc_status_t       stat_q;
	logic              rt_q;
	logic              out_v_q;
	logic [31:0]       out_exp_q;
	logic [1:0]        out_stat_q;
	logic              out_rt_q;

	logic [31:0] dsor;
	logic [32:0] rem33;
	logic        ge;
	logic [31:0] rem_nx;
	logic [63:0] mprod;
	drc_dec_t    dprev, dlim;
	logic [31:0] enc;
	logic        slot_free;

	assign dsor   = (state_q == B_MOD) ? cfg.retarget_interval : cfg.goal_span;
	assign rem33  = {rem_q, div_q[PROD_W-1]};
	assign ge     = (rem33 >= {1'b0, dsor});
	assign rem_nx = ge ? 32'(rem33 - {1'b0, dsor}) : rem33[31:0];
	assign mprod  = {32'd0, old_q[32*cnt_q[2:0] +: 32]} * {32'd0, it_q.span}
	                + {32'd0, carry_q};
	assign dprev  = drc_decode(it_q.parent_bits);
	assign dlim   = drc_decode(cfg.powlimit_bits);
	assign enc    = drc_encode(div_q[TGT_W-1:0]);
	assign slot_free = !out_v_q || !out_stall;
	assign pop    = (state_q == B_IDLE) && q_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_valid) begin
				if (pop_item.block_height != 32'd0 && cfg.retarget_interval != 32'd0)
					state_d = B_MOD;
				else
					state_d = B_RES;
			end
			B_MOD: if (cnt_q == CNT_W'(31)) state_d = B_CHK;
			B_CHK: state_d = (rem_q == 32'd0) ? B_DEC : B_RES;
			B_DEC: state_d = (dprev.ok && dlim.ok) ? B_MUL : B_RES;
			B_MUL: if (cnt_q == CNT_W'(NLIMB - 1)) begin
				state_d = (cfg.goal_span == 32'd0) ? B_CAP : B_DIV;
			end
			B_DIV: if (cnt_q == CNT_W'(PROD_W - 1)) state_d = B_CAP;
			B_CAP: state_d = B_ENC;
			B_ENC: state_d = B_RES;
			B_RES: if (slot_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_RES && slot_free)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				it_q   <= pop_item;
				div_q  <= {pop_item.block_height, {TGT_W{1'b0}}};
				rem_q  <= 32'd0;
				cnt_q  <= '0;
				rt_q   <= 1'b0;
				exp_q  <= pop_item.parent_bits;
				stat_q <= (pop_item.header_bits == pop_item.parent_bits) ? ST_MATCH
				                                                          : ST_MISMATCH;
			end
			B_MOD: begin
				rem_q <= rem_nx;
				div_q <= {div_q[PROD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			B_CHK: begin
				rt_q  <= (rem_q == 32'd0);
				cnt_q <= '0;
			end
			B_DEC: begin
				old_q   <= dprev.v;
				lim_q   <= dlim.v;
				carry_q <= 32'd0;
				cnt_q   <= '0;
				if (!(dprev.ok && dlim.ok)) begin
					exp_q  <= 32'd0;
					stat_q <= ST_INVALID;
				end
			end
			B_MUL: begin
				carry_q <= mprod[63:32];
				rem_q   <= 32'd0;
				if (cnt_q == CNT_W'(NLIMB - 1)) begin
					cnt_q <= '0;
					// zero goal span: quotient taken as all ones
					if (cfg.goal_span == 32'd0)
						div_q <= {mprod[63:32], {TGT_W{1'b1}}};
					else
						div_q <= {mprod[63:32], mprod[31:0], div_q[TGT_W-33:0]};
				end else begin
					cnt_q <= cnt_q + 1'b1;
					div_q[32*cnt_q[2:0] +: 32] <= mprod[31:0];
				end
			end
			B_DIV: begin
				rem_q <= rem_nx;
				div_q <= {div_q[PROD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			B_CAP: begin
				if (div_q[TGT_W-1:0] > lim_q)
					div_q[TGT_W-1:0] <= lim_q;
			end
			B_ENC: begin
				exp_q  <= enc;
				stat_q <= (it_q.header_bits == enc) ? ST_MATCH : ST_MISMATCH;
			end
			B_RES: begin
				if (slot_free) begin
					out_exp_q  <= exp_q;
					out_stat_q <= stat_q;
					out_rt_q   <= rt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_v_q;
	assign want_bits    = out_exp_q;
	assign check_status = out_stat_q;
	assign was_retarget = out_rt_q;

endmodule

// ===== hw/rtl/difficulty_retarget_check.sv =====
// ----------------------------------------------------------------------------
// difficulty_retarget_check
// Checks a header's compact difficulty against the value implied by the
// previous difficulty and the measured retarget period.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  in        in_valid/in_stall   block_height parent_bits period_start
//                                period_end header_bits
//  out       out_valid/out_stall want_bits check_status was_retarget
//  cfg       APB write/read      five 32-bit registers at 0x00..0x10
//
//  Engine steps per item: straight to the result when height or interval is
//  zero; a bit-serial modulo of the 32-bit height off a boundary; modulo and
//  decode for an invalid compact value; at a boundary, modulo, 8 multiply
//  limbs, bit-serial 288-bit divide (skipped for a zero goal span), cap, encode.
//  The front stage and a 4-deep queue keep taking items while the engine
//  works; the result register holds under out_stall. Reset loads defaults.
module difficulty_retarget_check import drc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] block_height,
	input  logic [31:0] parent_bits,
	input  logic [31:0] period_start,
	input  logic [31:0] period_end,
	input  logic [31:0] header_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] want_bits,
	output logic [1:0]  check_status,
	output logic        was_retarget
);

	drc_cfg_t  cfg_q;
	logic      push, full, q_valid, pop;
	drc_item_t push_item, pop_item;
	drc_reg_t  ridx;

	assign pready = 1'b1;
	assign ridx   = drc_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_span         <= RST_GOAL_SPAN;
			cfg_q.min_timespan      <= RST_MIN_TIMESPAN;
			cfg_q.max_timespan      <= RST_MAX_TIMESPAN;
			cfg_q.retarget_interval <= RST_RETARGET_INTERVAL;
			cfg_q.powlimit_bits     <= RST_POWLIMIT_BITS;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_GOAL_SPAN:         cfg_q.goal_span         <= pwdata;
				REG_MIN_TIMESPAN:      cfg_q.min_timespan      <= pwdata;
				REG_MAX_TIMESPAN:      cfg_q.max_timespan      <= pwdata;
				REG_RETARGET_INTERVAL: cfg_q.retarget_interval <= pwdata;
				REG_POWLIMIT_BITS:     cfg_q.powlimit_bits     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_GOAL_SPAN:         prdata = cfg_q.goal_span;
			REG_MIN_TIMESPAN:      prdata = cfg_q.min_timespan;
			REG_MAX_TIMESPAN:      prdata = cfg_q.max_timespan;
			REG_RETARGET_INTERVAL: prdata = cfg_q.retarget_interval;
			REG_POWLIMIT_BITS:     prdata = cfg_q.powlimit_bits;
			default:               prdata = 32'd0;
		endcase
	end

	drc_front u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid, .in_stall,
		.block_height, .parent_bits, .period_start, .period_end, .header_bits,
		.push, .push_item, .q_full(full)
	);

	drc_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full,
		.pop, .q_valid, .pop_item
	);

	drc_back u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.q_valid, .pop_item, .pop,
		.out_valid, .out_stall, .want_bits, .check_status, .was_retarget
	);

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for difficulty_retarget_check. Items are streamed with
// random bursts, gaps and output stalls over several register settings. Each
// result is compared with a 288-bit behavioral retarget calculation or a typed value.
// ----------------------------------------------------------------------------
module tb import drc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] bits;
		drc_status_t st;
		logic        rt;
	} verdict_t;

	typedef struct {
		logic [31:0] h, p, s, e, hdr;
		logic        typed;
		logic [31:0] xbits;
		drc_status_t xst;
		logic        xrt;
	} row_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [31:0] block_height, parent_bits, period_start, period_end, header_bits;
	logic        out_valid, out_stall;
	logic [31:0] want_bits;
	logic [1:0]  check_status;
	logic        was_retarget;

	logic [31:0] c_tts, c_min, c_max, c_ivl, c_pow;
	verdict_t    verdicts[$];
	int          n_err, n_sent, n_got, n_retarget, n_invalid;

	difficulty_retarget_check uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

	function automatic logic expand_compact(input logic [31:0] b, output logic [255:0] v);
		logic [255:0] m;
		m = {233'd0, b[22:0]};
		if (b[31:24] <= 8'd3)
			v = m >> (8 * (3 - b[31:24]));
		else
			v = m << (8 * (b[31:24] - 3));
		if (b[22:0] == 0)
			return 1'b1;
		return !(b[23] || b[31:24] > 34 || (b[22:0] > 23'hFF && b[31:24] > 33) ||
			(b[22:0] > 23'hFFFF && b[31:24] > 32));
	endfunction

	function automatic logic [31:0] pack_compact(input logic [255:0] v);
		int           size;
		logic [255:0] t;
		logic [23:0]  c;
		size = 0;
		for (int k = 0; k < 32; k++)
			if (v[8*k +: 8] != 0) size = k + 1;
		if (size <= 3) t = v << (8 * (3 - size));
		else t = v >> (8 * (size - 3));
		c = t[23:0];
		if (c[23]) begin
			c = c >> 8;
			size++;
		end
		return {size[7:0], c};
	endfunction

	function automatic verdict_t retarget_predict(input logic [31:0] h, p, s, e, hdr);
		logic [255:0] old_t, lim, q;
		logic [287:0] prodv, quo;
		logic [31:0]  span;
		logic         okp, okl;
		verdict_t     r;
		r.rt = h != 0 && c_ivl != 0 && (h % c_ivl) == 0;
		r.bits = p;
		if (r.rt) begin
			okp = expand_compact(p, old_t);
			okl = expand_compact(c_pow, lim);
			if (!okp || !okl) begin
				r.bits = 32'd0;
				r.st = ST_INVALID;
				return r;
			end
			span = (e < s) ? 32'd0 : e - s;
			if (span == 0) span = c_tts;
			if (span < c_min) span = c_min;
			else if (span > c_max) span = c_max;
			prodv = {32'd0, old_t} * {256'd0, span};
			quo = prodv / {256'd0, c_tts};
			q = (c_tts == 0) ? '1 : quo[255:0];
			if (q > lim) q = lim;
			r.bits = pack_compact(q);
		end
		r.st = (hdr == r.bits) ? ST_MATCH : ST_MISMATCH;
		return r;
	endfunction

	task automatic apb_write(input drc_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		pwrite = 0; penable = 0;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		if (prdata !== val) begin
			n_err++;
			if (n_err <= 10) $display("reg %s read %h wrote %h", idx.name(), prdata, val);
		end
		@(negedge clk);
		psel = 0; penable = 0;
		case (idx)
			REG_GOAL_SPAN:         c_tts = val;
			REG_MIN_TIMESPAN:      c_min = val;
			REG_MAX_TIMESPAN:      c_max = val;
			REG_RETARGET_INTERVAL: c_ivl = val;
			default:               c_pow = val;
		endcase
	endtask

	task automatic configure(input logic [31:0] t, mn, mx, iv, pw);
		wait (verdicts.size() == 0);
		repeat (400) @(posedge clk);
		apb_write(REG_GOAL_SPAN, t);
		apb_write(REG_MIN_TIMESPAN, mn);
		apb_write(REG_MAX_TIMESPAN, mx);
		apb_write(REG_RETARGET_INTERVAL, iv);
		apb_write(REG_POWLIMIT_BITS, pw);
	endtask

	// Called at a falling edge; raises in_valid, which the caller drops when done.
	task automatic offer_item(input logic [31:0] h, p, s, e, hdr);
		in_valid = 1;
		block_height = h; parent_bits = p; period_start = s; period_end = e;
		header_bits = hdr;
		do @(posedge clk); while (in_stall);
		verdicts.push_back(retarget_predict(h, p, s, e, hdr));
		n_sent++;
	endtask

	function automatic logic [31:0] rand_compact();
		case ($urandom_range(0, 5))
			0: return {8'h1d, 1'b0, 23'($urandom)};
			1: return {8'($urandom_range(1, 34)), 1'b0, 7'd0, 16'($urandom)};
			2: return {8'($urandom_range(3, 32)), 1'b0, 23'($urandom)};
			3: return {8'($urandom_range(0, 3)), 1'b0, 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input int count);
		logic [31:0] h, p, s, e, hdr;
		int          burst;
		verdict_t    v;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			@(negedge clk);
			if (burst == 0) begin
				in_valid = 0;
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge clk);
				burst = $urandom_range(1, 20);
			end
			burst--;
			if ($urandom_range(0, 9) < 7 && c_ivl != 0)
				h = c_ivl * $urandom_range(1, 3000);
			else
				h = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
			p = rand_compact();
			s = $urandom;
			case ($urandom_range(0, 5))
				0: e = $urandom;
				1: e = s;
				2: e = s - $urandom_range(1, 1000);
				default: e = s + $urandom_range(0, (c_max > 32'h7FFFFFFF) ? 32'hFFFFFFF
					: c_max + c_max / 2 + 1);
			endcase
			v = retarget_predict(h, p, s, e, 32'd0);
			hdr = ($urandom_range(0, 1)) ? v.bits : $urandom;
			offer_item(h, p, s, e, hdr);
		end
		@(negedge clk);
		in_valid = 0;
	endtask

	// directed rows, default registers
	row_t dir_rows[] = '{
		'{0, 32'h1d00ffff, 0, 0, 32'h1d00ffff, 1, 32'h1d00ffff, ST_MATCH, 0},
		'{2015, 32'h1b0404cb, 0, 0, 0, 1, 32'h1b0404cb, ST_MISMATCH, 0},
		'{2016, 32'h1d00ffff, 0, 1209600, 32'h1d00ffff, 1, 32'h1d00ffff, ST_MATCH, 1},
		'{4032, 32'h1d80ffff, 0, 10, 0, 1, 0, ST_INVALID, 1},
		'{2016, 32'h23000001, 0, 10, 0, 1, 0, ST_INVALID, 1},
		'{2016, 32'h2200ffff, 0, 10, 0, 1, 0, ST_INVALID, 1},
		'{2016, 32'h04800000, 5, 900000, 0, 1, 0, ST_MATCH, 1},
		'{32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, ST_MATCH, 0},
		'{2016, 32'h1b0404cb, 100, 50, 0, 0, 0, ST_MATCH, 0},
		'{2016, 32'h1b0404cb, 777, 777, 0, 0, 0, ST_MATCH, 0},
		'{2016, 32'h1b0404cb, 1000, 1001, 0, 0, 0, ST_MATCH, 0},
		'{2016, 32'h1b0404cb, 0, 32'hFFFFFFFF, 0, 0, 0, ST_MATCH, 0},
		'{32'hFFFFFF00, 32'h1c00ffff, 0, 600000, 32'h1c007fff, 0, 0, ST_MATCH, 0},
		'{6048, 32'h03123456, 0, 2000000, 0, 0, 0, ST_MATCH, 0},
		'{6048, 32'h01003456, 0, 2000000, 0, 0, 0, ST_MATCH, 0},
		'{8064, 32'h220000ff, 0, 4000000, 0, 0, 0, ST_MATCH, 0},
		'{2016, 32'h207fffff, 0, 0, 32'h1d00ffff, 0, 0, ST_MATCH, 0}
	};

	initial begin
		row_t r;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; block_height = 0; parent_bits = 0; period_start = 0;
		period_end = 0; header_bits = 0;
		n_err = 0; n_sent = 0; n_got = 0; n_retarget = 0; n_invalid = 0;
		c_tts = RST_GOAL_SPAN; c_min = RST_MIN_TIMESPAN; c_max = RST_MAX_TIMESPAN;
		c_ivl = RST_RETARGET_INTERVAL; c_pow = RST_POWLIMIT_BITS;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (3) @(negedge clk);
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			@(negedge clk);
			offer_item(r.h, r.p, r.s, r.e, r.hdr);
			if (r.typed) begin
				verdicts[$].bits = r.xbits;
				verdicts[$].st = r.xst;
				verdicts[$].rt = r.xrt;
			end
		end
		@(negedge clk);
		in_valid = 0;
		random_phase(100);
		configure(32'd1, 32'd0, 32'hFFFFFFFF, 32'd1, 32'h2100ffff);
		random_phase(90);
		configure(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'h207fffff);
		random_phase(80);
		configure(32'd0, 32'd100, 32'd1000, 32'd7, 32'h1d00ffff);
		random_phase(90);
		configure(32'd600, 32'd150, 32'd2400, 32'd0, 32'h1e0fffff);
		random_phase(70);
		configure(RST_GOAL_SPAN, RST_MIN_TIMESPAN, RST_MAX_TIMESPAN, 32'd2016,
			32'h23000001);
		random_phase(70);
		configure(32'd86400, 32'd21600, 32'd345600, 32'd144, 32'h1f7fffff);
		random_phase(100);
		configure($urandom_range(1, 5000000), $urandom_range(0, 100000),
			$urandom_range(100000, 9000000), $urandom_range(1, 50), $urandom);
		random_phase(90);
		wait (verdicts.size() == 0);
		repeat (400) @(posedge clk);
		$display("tb: %0d items, %0d retarget results (%0d invalid), 8 register settings",
			n_sent, n_retarget, n_invalid);
		$display("tb: %0d results checked, %0d mismatches", n_got, n_err);
		if (n_err == 0 && verdicts.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// output stall: shifting pattern plus one long hold-off to back up the queue
	initial begin
		int mode, left, hold;
		logic held;
		out_stall = 0; mode = 0; left = 0; hold = 0; held = 0;
		forever begin
			@(negedge clk);
			if (!held && n_sent >= 60) begin
				held = 1;
				hold = 3000;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 200);
			end
			left--;
			if (hold > 0) begin
				hold--;
				out_stall = 1;
			end else
				out_stall = (mode == 0) ? 1'b0 : ($urandom_range(0, 9) < mode * 3);
		end
	end

	always @(posedge clk) begin
		verdict_t x;
		if (arst_n && out_valid && !out_stall) begin
			n_got++;
			if (verdicts.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("result with nothing pending: %h", want_bits);
			end else begin
				x = verdicts.pop_front();
				if (x.rt) n_retarget++;
				if (x.st == ST_INVALID) n_invalid++;
				if (want_bits !== x.bits || check_status !== x.st ||
						was_retarget !== x.rt) begin
					n_err++;
					if (n_err <= 10)
						$display("result %0d: got %h/%0d/%b want %h/%0d/%b", n_got,
							want_bits, check_status, was_retarget, x.bits, x.st, x.rt);
				end
			end
		end
	end

endmodule

// ===== difficulty_retarget_check.f =====
hw/rtl/drc_pkg.sv
hw/rtl/drc_front.sv
hw/rtl/drc_queue.sv
hw/rtl/drc_back.sv
hw/rtl/difficulty_retarget_check.sv
tb/tb.sv
